// ===== src/hass_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and the quarter-wave sine generator function for the
// harmonic additive sine synthesizer. No dependencies.
package hass_pkg;

	// default sizing of the core
	localparam int MAX_PARTIALS_DEF    = 16;
	localparam int SINE_INDEX_BITS_DEF = 10;
	localparam int PHASE_BITS_DEF      = 32;

	// field widths
	localparam int AMP_W     = 16;
	localparam int OFFSET_W  = 16;
	localparam int SAMPLE_W  = 16;
	localparam int SINE_W    = 15;
	localparam int ENTRY_W   = AMP_W + OFFSET_W;
	localparam int IN_DATA_W = 40;

	// request codes on s_tuser
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_SAMPLE  = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_PHASE_STEP   = 1'b0;
	localparam logic REG_NUM_PARTIALS = 1'b1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Quarter-wave sine entry: Q30 Taylor series to x^15, each term truncated,
	// then rounded to Q15 and capped. Only evaluated at elaboration.
	function automatic logic [SINE_W-1:0] sine_value(input int unsigned idx,
		input int unsigned sib);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] v;
		logic signed [63:0] sum;
		int unsigned n;
		x = (HALF_PI_Q30 * (64'(2 * idx) + 64'd1)) >> (sib + 1);
		term = x;
		sum = $signed(x);
		for (n = 1; n <= 7; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		v = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[SINE_W-1:0];
	endfunction

endpackage

// ===== src/hass_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hass_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ===== src/hass_sine_rom.sv =====
`timescale 1ns / 1ps
// Quarter-wave sine ROM, 2^SINE_INDEX_BITS Q15 magnitudes, registered read.
// Depends on hass_pkg for the entry generator.
module hass_sine_rom #(
	parameter int SINE_INDEX_BITS = hass_pkg::SINE_INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic [SINE_INDEX_BITS-1:0]    addr,
	output logic [hass_pkg::SINE_W-1:0]   data_q
);

	localparam int SINE_LEN = 1 << SINE_INDEX_BITS;

	logic [hass_pkg::SINE_W-1:0] rom_w [SINE_LEN];

	for (genvar i = 0; i < SINE_LEN; i++) begin : g_rom
		assign rom_w[i] = hass_pkg::sine_value(i, SINE_INDEX_BITS);
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[addr];
	end

endmodule

// ===== src/harmonic_additive_sine_synth_core.sv =====
`timescale 1ns / 1ps
// Top level of the harmonic additive sine synthesizer: request handling,
// sequencer, shared multiply-accumulate and bit-serial divider.
// Depends on hass_pkg, hass_ram and hass_sine_rom.
//
// Usage:
//  Requests arrive on the s_ stream: s_tuser is the operation (write partial,
//  restart time base, make sample), s_tdata carries the partial fields.
//  Writes and restarts complete in the accept cycle and give no result.
//  A sample request produces one 16-bit sample on the m_ stream.
//  phase_step and num_partials are set over the APB port while idle.
//  A sample steps through ST_READ, ST_LOOK and ST_MUL for each of n partials,
//  where n is the effective partial count, then through ST_FIN, ST_DIV and
//  ST_OUT before m_tvalid. Each partial passes through the one table read,
//  sine lookup and 16x16 multiplier; the divide by n retires one quotient
//  bit per cycle, for 16 + clog2(MAX_PARTIALS) quotient bits.
//  s_tready is low while a sample is being computed.
//  The finished sample sits in an output register; if the receiver stalls
//  with a sample still pending, the next request is still taken, and a new
//  sample waits in its last step until the register frees up.
//  Reset clears all partials to disabled, base phase and phase_step to zero,
//  num_partials to one.
module harmonic_additive_sine_synth_core #(
	parameter int MAX_PARTIALS    = hass_pkg::MAX_PARTIALS_DEF,
	parameter int SINE_INDEX_BITS = hass_pkg::SINE_INDEX_BITS_DEF,
	parameter int PHASE_BITS      = hass_pkg::PHASE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [3:0] partial_index, [19:4] amplitude, [35:20] phase_offset,
	// [36] partial_enable, [39:37] zero
	input  logic [hass_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [1:0]                      s_tuser,
	// sample stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] sample
	output logic [hass_pkg::SAMPLE_W-1:0]   m_tdata,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [2:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int IDX_W  = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
	localparam int CNT_W  = $clog2(MAX_PARTIALS + 1);
	localparam int ACC_W  = 32 + $clog2(MAX_PARTIALS);
	localparam int MAG_W  = ACC_W - 16;
	localparam int DCNT_W = $clog2(MAG_W + 1);
	localparam int TOP_W  = SINE_INDEX_BITS + 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_LOOK = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]                     state_q;
	logic [31:0]                    step_q;
	logic [4:0]                     num_q;
	logic [PHASE_BITS-1:0]          base_q;
	logic [PHASE_BITS-1:0]          h_q;
	logic [MAX_PARTIALS-1:0]        en_q;
	logic [CNT_W-1:0]               k_q;
	logic signed [hass_pkg::AMP_W-1:0] amp_q;
	logic                           neg_q;
	logic signed [31:0]             prod_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic                           sign_q;
	logic [MAG_W-1:0]               dq_q;
	logic [CNT_W-1:0]               rem_q;
	logic [DCNT_W-1:0]              dcnt_q;
	logic                           m_tvalid_q;
	logic [hass_pkg::SAMPLE_W-1:0]  m_tdata_q;

	// request fields
	logic                           accept;
	logic [3:0]                     in_idx;
	logic [hass_pkg::AMP_W-1:0]     in_amp;
	logic [hass_pkg::OFFSET_W-1:0]  in_off;
	logic                           in_en;
	logic [IDX_W+3:0]               in_idx_ext;
	logic [IDX_W-1:0]               waddr;
	logic                           wr_ok;

	// datapath
	logic [CNT_W-1:0]               n_eff;
	logic [CNT_W-1:0]               k_next;
	logic [hass_pkg::ENTRY_W-1:0]   rd_entry;
	logic [PHASE_BITS-1:0]          phase;
	logic [TOP_W-1:0]               ph_top;
	logic [SINE_INDEX_BITS-1:0]     rom_addr;
	logic [hass_pkg::SINE_W-1:0]    rom_q;
	logic signed [15:0]             sine_s;
	logic signed [ACC_W-1:0]        acc_sum;
	logic [ACC_W-1:0]               acc_mag;
	logic [CNT_W:0]                 trial;
	logic [CNT_W:0]                 trial_diff;
	logic                           qbit;
	logic [15:0]                    q16;
	logic [hass_pkg::SAMPLE_W-1:0]  sat_val;
	logic                           out_free;
	logic                           cfg_wr;

	assign accept     = s_tvalid && s_tready;
	assign in_idx     = s_tdata[3:0];
	assign in_amp     = s_tdata[19:4];
	assign in_off     = s_tdata[35:20];
	assign in_en      = s_tdata[36];
	assign in_idx_ext = (IDX_W + 4)'(in_idx);
	assign waddr      = in_idx_ext[IDX_W-1:0];
	assign wr_ok      = accept && (s_tuser == hass_pkg::OP_WRITE) &&
		(32'(in_idx) < 32'(MAX_PARTIALS));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;
	assign out_free = !m_tvalid_q || m_tready;

	// configuration port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == hass_pkg::REG_NUM_PARTIALS) ? 32'(num_q) : step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			num_q  <= 5'd1;
		end else if (cfg_wr) begin
			if (paddr[2] == hass_pkg::REG_PHASE_STEP) begin
				step_q <= pwdata;
			end else begin
				num_q <= pwdata[4:0];
			end
		end
	end

	// zero partials act as one, too many act as the table size
	always_comb begin
		if (num_q == 5'd0) begin
			n_eff = CNT_W'(1);
		end else if (32'(num_q) > 32'(MAX_PARTIALS)) begin
			n_eff = CNT_W'(MAX_PARTIALS);
		end else begin
			n_eff = CNT_W'(num_q);
		end
	end

	assign k_next = k_q + CNT_W'(1);

	hass_ram #(
		.WIDTH (hass_pkg::ENTRY_W),
		.DEPTH (MAX_PARTIALS),
		.AW    (IDX_W)
	) u_table (
		.clk     (clk),
		.we      (wr_ok),
		.waddr   (waddr),
		.wdata   ({in_off, in_amp}),
		.raddr   (k_q[IDX_W-1:0]),
		.rdata_q (rd_entry)
	);

	// phase of harmonic k+1: running multiple of base phase plus offset
	assign phase = h_q +
		(PHASE_BITS'(rd_entry[hass_pkg::ENTRY_W-1:hass_pkg::AMP_W]) << (PHASE_BITS - 16));
	assign ph_top   = phase[PHASE_BITS-1 -: TOP_W];
	assign rom_addr = ph_top[SINE_INDEX_BITS] ? ~ph_top[SINE_INDEX_BITS-1:0] :
		ph_top[SINE_INDEX_BITS-1:0];

	hass_sine_rom #(
		.SINE_INDEX_BITS (SINE_INDEX_BITS)
	) u_sine (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_q)
	);

	assign sine_s  = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
	assign acc_sum = acc_q + ACC_W'(prod_q);
	assign acc_mag = acc_sum[ACC_W-1] ? $unsigned(-acc_sum) : $unsigned(acc_sum);

	// restoring divide step, one quotient bit per cycle
	assign trial      = {rem_q, dq_q[MAG_W-1]};
	assign trial_diff = trial - {1'b0, n_eff};
	assign qbit       = (trial >= {1'b0, n_eff});

	// sign and saturate the quotient magnitude
	assign q16 = dq_q[15:0];
	always_comb begin
		priority if (!sign_q && (dq_q > MAG_W'(32767))) begin
			sat_val = 16'h7FFF;
		end else if (sign_q && (dq_q > MAG_W'(32768))) begin
			sat_val = 16'h8000;
		end else if (sign_q) begin
			sat_val = ~q16 + 16'd1;
		end else begin
			sat_val = q16;
		end
	end

	// partial enables double as valid bits for the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (wr_ok) begin
			en_q[waddr] <= in_en;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			base_q     <= '0;
			k_q        <= '0;
			dcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == hass_pkg::OP_RESTART)) begin
						base_q <= '0;
					end
					if (accept && (s_tuser == hass_pkg::OP_SAMPLE)) begin
						k_q     <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					k_q <= k_next;
					if (k_next == n_eff) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_FIN: begin
					dcnt_q  <= DCNT_W'(MAG_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q - DCNT_W'(1);
					if (dcnt_q == DCNT_W'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						base_q     <= base_q + PHASE_BITS'(step_q);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				h_q    <= base_q;
				acc_q  <= '0;
				prod_q <= '0;
			end
			ST_READ: begin
				acc_q <= acc_sum;
			end
			ST_LOOK: begin
				amp_q <= en_q[k_q[IDX_W-1:0]] ?
					$signed(rd_entry[hass_pkg::AMP_W-1:0]) : '0;
				neg_q <= ph_top[SINE_INDEX_BITS+1];
			end
			ST_MUL: begin
				// silent partials add nothing, whatever the table holds
				prod_q <= (amp_q == 16'sd0) ? 32'sd0 : amp_q * sine_s;
				h_q    <= h_q + base_q;
			end
			ST_FIN: begin
				sign_q <= acc_sum[ACC_W-1];
				dq_q   <= acc_mag[ACC_W-2:15];
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= qbit ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
				dq_q  <= {dq_q[MAG_W-2:0], qbit};
			end
			ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= sat_val;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

// ===== src/hass_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the harmonic additive sine synthesizer, bound to the
// top level. Depends on hass_pkg for the request codes.
module hass_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        pready
);

	// stalled sample holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("sample changed or dropped while stalled");

	// a sample request blocks further requests
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == hass_pkg::OP_SAMPLE) |=> !s_tready)
		else $error("ready after sample request");

	// writes, restarts and unused codes finish at once
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != hass_pkg::OP_SAMPLE) |=> s_tready)
		else $error("non-sample request left the core busy");

	// a new sample only appears at the end of a busy period
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("sample appeared without a sample request");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind harmonic_additive_sine_synth_core hass_checker u_hass_checker (.*);
